[design/adjacency_vertex_merge_defines.svh]
// assertion macros for the adjacency vertex merge block
`ifndef ADJACENCY_VERTEX_MERGE_DEFINES_SVH
`define ADJACENCY_VERTEX_MERGE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define AVM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define AVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define AVM_ASSERT(lbl, clk, rstn, prop, msg)
`define AVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/avm_pkg.sv]
// shared types and constants of the adjacency vertex merge block
`default_nettype none

package avm_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 16;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VERTEX_W = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_WRITE    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_READ     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_IDENTIFY = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CONTRACT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESTART  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NOT_ADJ = 2'd2,
    ST_SAME    = 2'd3
  } status_e;

  typedef struct packed {
    logic scan;
    logic merge;
    logic wr;
    logic wr_val;
  } sweep_ctrl_t;

endpackage

`default_nettype wire

[design/avm_cell.sv]
// one adjacency row cell of the shifting row chain
`default_nettype none

module avm_cell
  import avm_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    shift_i,
  input  wire logic                    clear_i,
  input  wire logic [MAX_VERTICES-1:0] row_i,
  output logic      [MAX_VERTICES-1:0] row_o
);

  logic [MAX_VERTICES-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (clear_i) begin
      row_q <= '0;
    end else if (shift_i) begin
      row_q <= row_i;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

[design/avm_sweep.sv]
// head of the row chain: edge capture, write update and merge compaction
`default_nettype none

module avm_sweep
  import avm_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int unsigned IW = $clog2(MAX_VERTICES),
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sweep_ctrl_t                  ctrl_i,
  input  wire logic [IW-1:0]                step_i,
  input  wire logic [IW-1:0]                a_i,
  input  wire logic [IW-1:0]                b_i,
  input  wire logic [IW-1:0]                lo_i,
  input  wire logic [IW-1:0]                hi_i,
  input  wire logic [CW-1:0]                last_i,
  input  wire logic [2:0][MAX_VERTICES-1:0] win_i,
  output logic      [MAX_VERTICES-1:0]      tail_o,
  output logic                              edge_o
);

  logic [MAX_VERTICES-1:0] q_q;
  logic [MAX_VERTICES-1:0] q_d;
  logic                    edge_q;
  logic [MAX_VERTICES-1:0] row0;
  logic [MAX_VERTICES-1:0] wr_row;
  logic [MAX_VERTICES-1:0] src_row;
  logic [MAX_VERTICES-1:0] last_mask;
  logic [MAX_VERTICES-1:0] merge_row;
  logic                    src_q_bit;

  function automatic logic [MAX_VERTICES-1:0] squeeze(
    input logic [MAX_VERTICES-1:0] row,
    input logic [IW-1:0]           lo,
    input logic [IW-1:0]           hi
  );
    logic [MAX_VERTICES+1:0] pad;
    logic [MAX_VERTICES-1:0] r;
    pad = {2'b00, row};
    r   = '0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (IW'(k) < lo) begin
        r[k] = pad[k];
      end else if ((IW+1)'(k + 1) < {1'b0, hi}) begin
        r[k] = pad[k+1];
      end else begin
        r[k] = pad[k+2];
      end
    end
    return r;
  endfunction

  assign row0 = win_i[0];

  // write both directions of the edge as the rows pass the head
  always_comb begin
    wr_row = row0;
    if (ctrl_i.wr && step_i == a_i) begin
      wr_row[b_i] = ctrl_i.wr_val;
    end
    if (ctrl_i.wr && step_i == b_i) begin
      wr_row[a_i] = ctrl_i.wr_val;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      last_mask[k] = (CW'(k) == last_i);
    end
  end

  // source row of output position step: skip over the lo and hi rows
  always_comb begin
    if (step_i < lo_i) begin
      src_row = win_i[0];
    end else if ((IW+1)'(step_i) + (IW+1)'(1) < {1'b0, hi_i}) begin
      src_row = win_i[1];
    end else begin
      src_row = win_i[2];
    end
    src_q_bit = src_row[a_i] | src_row[b_i];
  end

  always_comb begin
    if (CW'(step_i) < last_i) begin
      merge_row = squeeze(src_row, lo_i, hi_i) | (src_q_bit ? last_mask : '0);
    end else if (CW'(step_i) == last_i) begin
      merge_row = squeeze(q_q, lo_i, hi_i) | ((q_q[lo_i] | q_q[hi_i]) ? last_mask : '0);
    end else begin
      merge_row = '0;
    end
  end

  always_comb begin
    q_d = (step_i == '0) ? '0 : q_q;
    if (step_i == a_i || step_i == b_i) begin
      q_d = q_d | row0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan) begin
      q_q <= q_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= 1'b0;
    end else if (ctrl_i.scan && step_i == a_i) begin
      edge_q <= row0[b_i];
    end
  end

  assign tail_o = ctrl_i.merge ? merge_row : wr_row;
  assign edge_o = edge_q;

endmodule

`default_nettype wire

[design/adjacency_vertex_merge.sv]
// adjacency vertex merge: graph kept as a chain of adjacency row cells
//
// requests enter on the s_ side, one result per request leaves on the m_ side.
// the configuration channel writes the vertex count loaded by a restart; it
// is always ready. it must be written only while the block is idle; the block itself does not enforce this.
// one request is worked on at a time. the rows circulate through the cell
// chain one position per cycle, the head cell feeding the sweep unit:
//   write, read: one pass from request to result
//   identify, contract: two passes, a scan pass and a merge pass
//   refused merge: one pass
//   restart, out of range, unused codes: no pass
// a new request is taken in the cycle after the result is loaded.
// the pass length is set by the chain depth, one row per cycle.
// the result sits in an output register; while the receiver stalls the
// finished result is held and the next request waits.
// reset clears all rows, sets the live count to MAX_VERTICES and the
// restart count to 16.
`default_nettype none

`include "adjacency_vertex_merge_defines.svh"

module adjacency_vertex_merge
  import avm_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [4:0]   cfg_data_i,   // initial_vertex_count
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  input  wire logic [15:0]  s_tdata_i,    // action[2:0], vertex_a[6:3], vertex_b[10:7], edge_value[11]
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  output logic [7:0]        m_tdata_o     // edge_bit[0], vertex_count[5:1], status[7:6]
);

  localparam int unsigned IW   = $clog2(MAX_VERTICES);
  localparam int unsigned CW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CMPW = (CW > VERTEX_W) ? CW : VERTEX_W;
  localparam int unsigned SATW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MERGE,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [IW-1:0]         step_q;
  logic [ACTION_W-1:0]   act_q;
  logic [VERTEX_W-1:0]   a_q;
  logic [VERTEX_W-1:0]   b_q;
  logic                  v_q;
  status_e               status_q;
  logic [CW-1:0]         live_q;
  logic [COUNT_W-1:0]    cfg_q;
  logic                  m_valid_q;
  logic                  m_edge_q;
  logic [COUNT_W-1:0]    m_count_q;
  status_e               m_status_q;

  logic [ACTION_W-1:0]   in_act;
  logic [VERTEX_W-1:0]   in_a;
  logic [VERTEX_W-1:0]   in_b;
  logic                  in_v;
  logic                  in_req;
  logic                  in_range;
  logic [CW-1:0]         restart_count;
  logic                  step_last;
  logic [IW-1:0]         a_ix;
  logic [IW-1:0]         b_ix;
  logic [IW-1:0]         lo_ix;
  logic [IW-1:0]         hi_ix;
  logic [CW-1:0]         last_pos;
  logic                  edge_bit;
  logic                  out_edge;
  logic                  out_load;
  logic                  chain_shift;
  logic                  chain_clear;
  sweep_ctrl_t           sweep_ctrl;

  logic [MAX_VERTICES-1:0]       row [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]       tail_row;
  logic [2:0][MAX_VERTICES-1:0]  win;

  assign in_act = s_tdata_i[2:0];
  assign in_a   = s_tdata_i[6:3];
  assign in_b   = s_tdata_i[10:7];
  assign in_v   = s_tdata_i[11];

  assign s_tready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_req      = s_tvalid_i && s_tready_o;

  assign in_range = (CMPW'(in_a) < CMPW'(live_q)) && (CMPW'(in_b) < CMPW'(live_q))
                 && (CMPW'(in_a) < CMPW'(MAX_VERTICES))
                 && (CMPW'(in_b) < CMPW'(MAX_VERTICES));

  assign restart_count = (SATW'(cfg_q) > SATW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                              : CW'(cfg_q);

  assign step_last = (step_q == IW'(MAX_VERTICES - 1));
  assign a_ix      = IW'(a_q);
  assign b_ix      = IW'(b_q);
  assign lo_ix     = (a_ix < b_ix) ? a_ix : b_ix;
  assign hi_ix     = (a_ix < b_ix) ? b_ix : a_ix;
  assign last_pos  = live_q - CW'(2);

  assign chain_shift = (state_q == S_SCAN) || (state_q == S_MERGE);
  assign chain_clear = in_req && (in_act == ACT_RESTART);

  assign sweep_ctrl.scan   = (state_q == S_SCAN);
  assign sweep_ctrl.merge  = (state_q == S_MERGE);
  assign sweep_ctrl.wr     = (state_q == S_SCAN) && (act_q == ACT_WRITE);
  assign sweep_ctrl.wr_val = v_q;

  assign out_edge = (status_q != ST_RANGE) && (act_q <= ACT_CONTRACT) && edge_bit;
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_tready_i);

  // row chain: each cell takes its upper neighbor, the last takes the sweep output
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    logic [MAX_VERTICES-1:0] next_row;
    if (i == MAX_VERTICES - 1) begin : g_tail
      assign next_row = tail_row;
    end else begin : g_mid
      assign next_row = row[i+1];
    end
    avm_cell #(
      .MAX_VERTICES(MAX_VERTICES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(chain_shift),
      .clear_i(chain_clear),
      .row_i  (next_row),
      .row_o  (row[i])
    );
  end

  assign win[0] = row[0];
  assign win[1] = row[1];
  if (MAX_VERTICES > 2) begin : g_win_wide
    assign win[2] = row[2];
  end else begin : g_win_narrow
    assign win[2] = '0;
  end

  avm_sweep #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_sweep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(sweep_ctrl),
    .step_i(step_q),
    .a_i   (a_ix),
    .b_i   (b_ix),
    .lo_i  (lo_ix),
    .hi_i  (hi_ix),
    .last_i(last_pos),
    .win_i (win),
    .tail_o(tail_row),
    .edge_o(edge_bit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      act_q      <= ACT_WRITE;
      a_q        <= '0;
      b_q        <= '0;
      v_q        <= 1'b0;
      status_q   <= ST_OK;
      live_q     <= CW'(MAX_VERTICES);
      cfg_q      <= COUNT_W'(16);
      m_valid_q  <= 1'b0;
      m_edge_q   <= 1'b0;
      m_count_q  <= '0;
      m_status_q <= ST_OK;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_req) begin
            act_q    <= in_act;
            a_q      <= in_a;
            b_q      <= in_b;
            v_q      <= in_v;
            step_q   <= '0;
            status_q <= ST_OK;
            if (in_act <= ACT_CONTRACT) begin
              if (in_range) begin
                state_q <= S_SCAN;
              end else begin
                status_q <= ST_RANGE;
                state_q  <= S_DONE;
              end
            end else begin
              if (in_act == ACT_RESTART) begin
                live_q <= restart_count;
              end
              state_q <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          step_q <= step_q + IW'(1);
          if (step_last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          step_q  <= '0;
          state_q <= S_DONE;
          if (act_q == ACT_IDENTIFY || act_q == ACT_CONTRACT) begin
            if (a_q == b_q) begin
              status_q <= ST_SAME;
            end else if (act_q == ACT_CONTRACT && !edge_bit) begin
              status_q <= ST_NOT_ADJ;
            end else begin
              state_q <= S_MERGE;
            end
          end
        end
        S_MERGE: begin
          step_q <= step_q + IW'(1);
          if (step_last) begin
            live_q  <= live_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_edge_q   <= out_edge;
            m_count_q  <= COUNT_W'(live_q);
            m_status_q <= status_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {m_status_q, m_count_q, m_edge_q};

  `AVM_ASSERT(a_merge_needs_two, clk_i, rst_ni, (state_q == S_MERGE) |-> (live_q >= CW'(2)), "merge with fewer than two live vertices")
  `AVM_ASSERT_NEXT(a_merge_dec, clk_i, rst_ni, state_q == S_MERGE && step_last, live_q == $past(live_q) - CW'(1), "merge did not decrement the live count")
  `AVM_ASSERT(a_dead_row_zero, clk_i, rst_ni, (state_q == S_IDLE && live_q < CW'(MAX_VERTICES)) |-> (row[MAX_VERTICES-1] == '0), "row beyond the live count is not zero")
  `AVM_ASSERT(a_live_max, clk_i, rst_ni, live_q <= CW'(MAX_VERTICES), "live count above the row count")

endmodule

`default_nettype wire
